// File: rtl/core/point_segment_distance_macros.svh
// Assertion macros for the point-to-segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("point_segment_distance: assertion failed");
// Condition must never be seen out of reset.
`define PSD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("point_segment_distance: forbidden condition");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/core/psd_pkg.sv
// Shared widths, case codes and root pipeline word for the distance block.
package psd_pkg;
  localparam int CW = 24;          // coordinate width
  localparam int DW = CW + 1;      // distance width, also root iterations
  localparam int MW = 2 * CW + 2;  // product / squared length magnitude width
  localparam int HW = MW / 2;      // half split for squaring
  localparam int NW = 2 * MW;      // squared cross product width
  localparam int PW = MW + DW;     // root * den accumulator width
  localparam int BW = $clog2(DW);  // root bit index width

  localparam logic [1:0] CASE_DEGEN    = 2'd0;
  localparam logic [1:0] CASE_BEFORE   = 2'd1;
  localparam logic [1:0] CASE_PAST     = 2'd2;
  localparam logic [1:0] CASE_INTERIOR = 2'd3;

  typedef struct packed {
    logic [NW-1:0] rem;   // num - root^2 * den
    logic [PW-1:0] acc;   // root * den
    logic [MW-1:0] den;
    logic [DW-1:0] root;
    logic [1:0]    code;
  } psd_root_t;
endpackage

// File: rtl/core/point_segment_distance.sv
// Top level: pipelined exact distance from a point to a line segment.
// Takes one word per cycle while the output is not stalled and returns one result
// word per input word, in order. Six stages of differences, products, sums,
// case selection and squaring come first, then one pipeline stage per result bit of the
// ratio square root. The whole pipeline advances together; it halts only
// while a result is held at the output and not taken. Distance is the floor
// of the exact Euclidean distance as an unsigned integer (Q25.0), case_code tells which rule applied.
`include "point_segment_distance_macros.svh"
module point_segment_distance (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [psd_pkg::CW-1:0] start_x_i,
  input  logic signed [psd_pkg::CW-1:0] start_y_i,
  input  logic signed [psd_pkg::CW-1:0] end_x_i,
  input  logic signed [psd_pkg::CW-1:0] end_y_i,
  input  logic signed [psd_pkg::CW-1:0] point_x_i,
  input  logic signed [psd_pkg::CW-1:0] point_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [psd_pkg::DW-1:0]      distance_o,
  output logic [1:0]                  case_code_o
);
  import psd_pkg::*;

  // global advance: pipeline moves unless the output word is stalled
  logic en;
  logic [5:0] vld_q;

  // stage 1: differences d = end-start, v = point-start, w = point-end
  logic signed [CW:0] dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;
  // stage 2: products
  logic signed [MW-1:0] dxdx_q, dydy_q, vxdx_q, vydy_q, dxvy_q, dyvx_q;
  logic signed [MW-1:0] vxvx_q, vyvy_q, wxwx_q, wywy_q;
  // stage 3: inner products
  logic signed [MW:0] len2_q, dot_q, cr_q, lv_q, lw_q;
  // stage 4: case and selected operands
  logic [1:0]    code4_q;
  logic [MW-1:0] crm_q, small_q, den4_q;
  logic [MW:0]   crm_d;
  logic [1:0]    code4_d;
  // stage 5: partial squares of |cross|
  logic [MW-1:0] hh_q, hl_q, ll_q, small5_q, den5_q;
  logic [1:0]    code5_q;
  // stage 6: root pipeline input
  psd_root_t     root6_q, root6_d;
  logic [NW-1:0] sq;

  psd_root_t     stg   [DW+1];
  logic          stg_v [DW+1];

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_comb begin
    code4_d = CASE_INTERIOR;
    if (len2_q == '0) begin
      code4_d = CASE_DEGEN;
    end else if (dot_q < 0) begin
      code4_d = CASE_BEFORE;
    end else if (dot_q > len2_q) begin
      code4_d = CASE_PAST;
    end
    crm_d = cr_q[MW] ? -cr_q : cr_q;
  end

  always_comb begin
    sq = ({{(NW - MW){1'b0}}, hh_q} << (2 * HW))
       + ({{(NW - MW){1'b0}}, hl_q} << (HW + 1))
       + {{(NW - MW){1'b0}}, ll_q};
    root6_d.acc  = '0;
    root6_d.root = '0;
    root6_d.code = code5_q;
    root6_d.den  = den5_q;
    root6_d.rem  = (code5_q == CASE_INTERIOR) ? sq : {{(NW - MW){1'b0}}, small5_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= (CW+1)'(end_x_i)   - (CW+1)'(start_x_i);
      dy_q <= (CW+1)'(end_y_i)   - (CW+1)'(start_y_i);
      vx_q <= (CW+1)'(point_x_i) - (CW+1)'(start_x_i);
      vy_q <= (CW+1)'(point_y_i) - (CW+1)'(start_y_i);
      wx_q <= (CW+1)'(point_x_i) - (CW+1)'(end_x_i);
      wy_q <= (CW+1)'(point_y_i) - (CW+1)'(end_y_i);

      dxdx_q <= MW'(dx_q) * MW'(dx_q);
      dydy_q <= MW'(dy_q) * MW'(dy_q);
      vxdx_q <= MW'(vx_q) * MW'(dx_q);
      vydy_q <= MW'(vy_q) * MW'(dy_q);
      dxvy_q <= MW'(dx_q) * MW'(vy_q);
      dyvx_q <= MW'(dy_q) * MW'(vx_q);
      vxvx_q <= MW'(vx_q) * MW'(vx_q);
      vyvy_q <= MW'(vy_q) * MW'(vy_q);
      wxwx_q <= MW'(wx_q) * MW'(wx_q);
      wywy_q <= MW'(wy_q) * MW'(wy_q);

      len2_q <= (MW+1)'(dxdx_q) + (MW+1)'(dydy_q);
      dot_q  <= (MW+1)'(vxdx_q) + (MW+1)'(vydy_q);
      cr_q   <= (MW+1)'(dxvy_q) - (MW+1)'(dyvx_q);
      lv_q   <= (MW+1)'(vxvx_q) + (MW+1)'(vyvy_q);
      lw_q   <= (MW+1)'(wxwx_q) + (MW+1)'(wywy_q);

      code4_q <= code4_d;
      crm_q   <= crm_d[MW-1:0];
      small_q <= (code4_d == CASE_PAST) ? lw_q[MW-1:0] : lv_q[MW-1:0];
      den4_q  <= (code4_d == CASE_INTERIOR) ? len2_q[MW-1:0] : MW'(1);

      hh_q     <= MW'(crm_q[MW-1:HW]) * MW'(crm_q[MW-1:HW]);
      hl_q     <= MW'(crm_q[MW-1:HW]) * MW'(crm_q[HW-1:0]);
      ll_q     <= MW'(crm_q[HW-1:0]) * MW'(crm_q[HW-1:0]);
      small5_q <= small_q;
      den5_q   <= den4_q;
      code5_q  <= code4_q;

      root6_q <= root6_d;
    end
  end

  assign stg[DW]   = root6_q;
  assign stg_v[DW] = vld_q[5];

  // root bits from the top down, one stage each
  for (genvar k = 0; k < DW; k++) begin : g_root
    psd_root_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (BW'(k)),
      .valid_i (stg_v[k+1]),
      .data_i  (stg[k+1]),
      .valid_o (stg_v[k]),
      .data_o  (stg[k])
    );
  end

  assign out_valid_o = stg_v[0];
  assign distance_o  = stg[0].root;
  assign case_code_o = stg[0].code;

  // non-interior cases take a plain square root
  `PSD_ASSERT(a_den_one, vld_q[5] && (root6_q.code != CASE_INTERIOR) |-> root6_q.den == MW'(1))
  // a stalled output freezes the front of the pipeline too
  `PSD_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> $stable(vld_q))
  // interior divisor is never zero
  `PSD_ASSERT_NEVER(a_den_zero, vld_q[5] && root6_q.den == '0)
endmodule

// File: rtl/core/psd_root_stage.sv
// One bit of the pipelined ratio square root: largest q with q*q*den <= num.
module psd_root_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [psd_pkg::BW-1:0] bit_i,
  input  logic                 valid_i,
  input  psd_pkg::psd_root_t   data_i,
  output logic                 valid_o,
  output psd_pkg::psd_root_t   data_o
);
  import psd_pkg::*;

  logic               valid_q;
  psd_root_t          data_q, data_d;
  logic [NW:0]        trial;
  logic [NW:0]        acc_sh;
  logic [NW:0]        den_sh;

  // trial = (acc << (b+1)) + (den << 2b) = ((q + 2^b)^2 - q^2) * den
  always_comb begin
    acc_sh = {{(NW + 1 - PW){1'b0}}, data_i.acc} << ({1'b0, bit_i} + 1'b1);
    den_sh = {{(NW + 1 - MW){1'b0}}, data_i.den} << {bit_i, 1'b0};
    trial  = acc_sh + den_sh;
    data_d = data_i;
    if ({1'b0, data_i.rem} >= trial) begin
      data_d.rem  = data_i.rem - trial[NW-1:0];
      data_d.acc  = data_i.acc + (PW'(data_i.den) << bit_i);
      data_d.root = data_i.root | (DW'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: tb/tb_point_segment_distance.sv
// Testbench for the point-to-segment distance pipeline: directed, random and stall tests.
`timescale 1ns / 1ps
module tb_point_segment_distance;
  import psd_pkg::*;

  localparam int  N_RANDOM    = 1100;
  localparam int  HOLD_CYCLES = 200;      // long receiver hold-off, well past the pipe depth
  localparam int  DRAIN_WAIT  = 40;       // pipe is 31 deep
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [CW-1:0] point_x_i = '0, point_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DW-1:0] distance_o;
  logic [1:0] case_code_o;

  point_segment_distance i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i, .point_x_i, .point_y_i,
    .out_valid_o, .out_ready_i, .distance_o, .case_code_o
  );

  typedef struct {
    logic [DW-1:0] dist_val;
    logic [1:0]    code;
  } dist_word_t;

  dist_word_t dist_expected_q[$];
  int unsigned words_in, words_out, mismatches;
  int unsigned code_seen[4];
  longint cycles;
  int  send_max_gap = 14;   // 0 gives back-to-back words
  int  recv_max_gap = 14;
  bit  hold_req;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Exact floor of the distance, using wide integers so no compare rounds.
  function automatic dist_word_t calc_distance(
    input logic signed [CW-1:0] sx, sy, ex, ey, px, py
  );
    logic signed [127:0] dx, dy, vx, vy, wx, wy, len2, dot, cr;
    logic [191:0] num, den, q, t;
    dist_word_t r;
    dx = ex - sx; dy = ey - sy;
    vx = px - sx; vy = py - sy;
    wx = px - ex; wy = py - ey;
    len2 = dx * dx + dy * dy;
    dot  = vx * dx + vy * dy;
    den  = 192'd1;
    if (len2 == 0) begin
      r.code = CASE_DEGEN;
      num = vx * vx + vy * vy;
    end else if (dot < 0) begin
      r.code = CASE_BEFORE;
      num = vx * vx + vy * vy;
    end else if (dot > len2) begin
      r.code = CASE_PAST;
      num = wx * wx + wy * wy;
    end else begin
      r.code = CASE_INTERIOR;
      cr = dx * vy - dy * vx;
      if (cr < 0) cr = -cr;
      num = cr * cr;
      den = len2;
    end
    // bitwise root: largest q with q^2 * den <= num
    q = '0;
    for (int b = 40; b >= 0; b--) begin
      t = q | (192'd1 << b);
      if (t * t * den <= num) q = t;
    end
    r.dist_val = q[DW-1:0];
    return r;
  endfunction

  // Monitor: sample both handshakes at the rising edge; retire before queueing.
  always @(posedge clk_i) begin
    dist_word_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, dist_expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.dist_val = distance_o;
      got.code = case_code_o;
      words_out++;
      if (dist_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: dist=%0d code=%0d", got.dist_val, got.code);
      end else begin
        want = dist_expected_q.pop_front();
        code_seen[want.code]++;
        if (got.dist_val !== want.dist_val || got.code !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on word %0d: dist exp %0d got %0d, code exp %0d got %0d",
                     words_out, want.dist_val, got.dist_val, want.code, got.code);
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      dist_expected_q.push_back(calc_distance(start_x_i, start_y_i, end_x_i, end_y_i,
                                              point_x_i, point_y_i));
      words_in++;
    end
  end

  // Receiver: random ready gaps, plus a long hold-off when asked.
  initial begin
    int unsigned snap;
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = $urandom_range(recv_max_gap, 0);
        if (gap > 0) begin
          out_ready_i = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end else begin
          out_ready_i = 1'b1;
          snap = words_out;
          while (words_out == snap && !hold_req) @(negedge clk_i);
          if (hold_req) out_ready_i = 1'b0;
        end
      end
    end
  end

  // Drive one word at the falling edge and hold it until the monitor sees it taken.
  task automatic send_word(input logic signed [CW-1:0] sx, sy, ex, ey, px, py);
    int gap;
    int unsigned snap;
    gap = $urandom_range(send_max_gap, 0);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_x_i = sx; start_y_i = sy;
    end_x_i = ex;   end_y_i = ey;
    point_x_i = px; point_y_i = py;
    in_valid_i = 1'b1;
    snap = words_in;
    do @(negedge clk_i); while (words_in == snap);
    // taken: drop valid; a following word raises it again in the same step
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (dist_expected_q.size() != 0) @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Extremes, each rule, and the two projection bounds that still count as interior.
  task automatic test_directed();
    send_word(0, 0, 0, 0, 0, 0);                       // degenerate at origin
    send_word(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);     // degenerate, far point
    send_word(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);     // degenerate, max distance
    send_word(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN);     // long diagonal, interior
    send_word(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN);     // point at start
    send_word(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);     // point at end
    send_word(CMIN, 0, CMAX, 0, 0, CMAX);              // horizontal, interior
    send_word(0, 0, 256, 0, 0, 100);                   // projection exactly at start
    send_word(0, 0, 256, 0, 256, 100);                 // projection exactly at end
    send_word(0, 0, 256, 0, -1, 100);                  // just before start
    send_word(0, 0, 256, 0, 257, 100);                 // just past end
    send_word(0, 0, 1, 0, CMIN, CMIN);                 // before start, far
    send_word(0, 0, 1, 0, CMAX, CMAX);                 // past end, far
    send_word(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN);     // reversed diagonal
    send_word(0, 0, 3 * 256, 4 * 256, 4 * 256, -3 * 256);
    send_word(100, -200, 101, -199, 50, 50);
    send_word(-1, -1, 0, 0, 0, -1);
    send_word(CMAX, CMAX, CMAX - 1, CMAX, CMIN, CMIN);
    send_word(CMIN, CMAX, CMAX, CMIN, 0, 0);
    send_word(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'h0f0f0f, 24'hf0f0f0);
    wait_drained();
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input int spread);
    if (spread == 0) return CW'($urandom);
    return CW'($signed($urandom_range(2 * spread, 0)) - spread);
  endfunction

  // Mix of full-range words and small segments with points near them.
  task automatic test_random();
    logic signed [CW-1:0] sx, sy, ex, ey;
    int spread;
    for (int n = 0; n < N_RANDOM; n++) begin
      // every few hundred words run a stretch with no idling on either side
      if (n % 300 == 150) begin send_max_gap = 0; recv_max_gap = 0; end
      if (n % 300 == 250) begin send_max_gap = 14; recv_max_gap = 14; end
      case ($urandom_range(3, 0))
        0: spread = 0;
        1: spread = 4000;
        2: spread = 200;
        default: spread = 3;
      endcase
      sx = rand_coord(spread); sy = rand_coord(spread);
      if ($urandom_range(15, 0) == 0) begin
        ex = sx; ey = sy;
      end else begin
        ex = rand_coord(spread); ey = rand_coord(spread);
      end
      send_word(sx, sy, ex, ey, rand_coord(spread), rand_coord(spread));
    end
    send_max_gap = 14; recv_max_gap = 14;
    wait_drained();
  endtask

  // Receiver holds off while words keep coming, so the pipe fills and stalls input.
  task automatic test_backpressure();
    send_max_gap = 0;
    hold_req = 1'b1;
    for (int n = 0; n < 60; n++)
      send_word(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                rand_coord(300), rand_coord(300));
    send_max_gap = 14;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    $display("%0d words sent, %0d results checked; cases degen/before/past/interior = %0d/%0d/%0d/%0d",
             words_in, words_out, code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
    $display("covered extremes, projection bounds, random gaps and a long output stall");
    if (mismatches == 0 && dist_expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, dist_expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: point_segment_distance.f
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_root_stage.sv
rtl/core/point_segment_distance.sv
tb/tb_point_segment_distance.sv
